>>> design/tbp_pkg.sv
package tbp_pkg;

    // default widths and register settings
    localparam int POS_WIDTH_DEF     = 40;
    localparam int ACC_FRAC_BITS_DEF = 48;
    localparam int GM_WIDTH          = 48;
    localparam int ACC_WIDTH         = 64;
    localparam int FIFO_DEPTH        = 2;

    localparam logic [GM_WIDTH-1:0] GM_RESET = 48'd4902800066000;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SQ,
        ST_SQRT,
        ST_DEN,
        ST_NSET,
        ST_NUM,
        ST_DIV
    } t_state;

endpackage

>>> design/tbp_front.sv
module tbp_front #(
    parameter int POS_WIDTH = 40
) (
    input  logic signed [POS_WIDTH-1:0]   i_craft [3],
    input  logic signed [POS_WIDTH-1:0]   i_body  [3],
    output logic [6*(POS_WIDTH+1)+6:0]    o_item
);
    localparam int M = POS_WIDTH + 1;

    logic signed [M-1:0] d     [3];
    logic signed [M-1:0] b     [3];
    logic        [M-1:0] mag_d [3];
    logic        [M-1:0] mag_b [3];
    logic                neg_d [3];
    logic                neg_b [3];
    logic                zero_d;
    logic                zero_b;

    // relative vector, signs and magnitudes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            b[i]     = {i_body[i][POS_WIDTH-1], i_body[i]};
            d[i]     = b[i] - {i_craft[i][POS_WIDTH-1], i_craft[i]};
            neg_d[i] = d[i][M-1];
            neg_b[i] = b[i][M-1];
            mag_d[i] = neg_d[i] ? M'(-d[i]) : M'(d[i]);
            mag_b[i] = neg_b[i] ? M'(-b[i]) : M'(b[i]);
        end
    end

    // zero distance classification
    assign zero_d = (mag_d[0] == '0) && (mag_d[1] == '0) && (mag_d[2] == '0);
    assign zero_b = (mag_b[0] == '0) && (mag_b[1] == '0) && (mag_b[2] == '0);

    // item packing for the queue
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_item[i*M +: M]     = mag_d[i];
            o_item[(3+i)*M +: M] = mag_b[i];
            o_item[6*M+i]        = neg_d[i];
            o_item[6*M+3+i]      = neg_b[i];
        end
        o_item[6*M+6] = zero_d | zero_b;
    end

endmodule

>>> design/tbp_fifo.sv
module tbp_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    import tbp_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(FIFO_DEPTH));
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> design/tbp_sqrt.sv
module tbp_sqrt #(
    parameter int POS_WIDTH = 40
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [2*(POS_WIDTH+1)-1:0]  i_rad,
    output logic [POS_WIDTH:0]          o_root,
    output logic                        o_done
);
    localparam int M  = POS_WIDTH + 1;
    localparam int QW = 2 * M;
    localparam int CW = $clog2(M);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [QW-1:0] r_rad;
    logic [M:0]    r_rem;
    logic [M-1:0]  r_root;
    logic [M+2:0]  rem_sh;
    logic [M+2:0]  trial;
    logic          ge;

    // one root bit per cycle
    assign rem_sh = {r_rem, r_rad[QW-1:QW-2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    assign o_root = r_root;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(M - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[QW-3:0], 2'b00};
            r_rem  <= ge ? (M+1)'(rem_sh - trial) : (M+1)'(rem_sh);
            r_root <= {r_root[M-2:0], ge};
        end
    end

endmodule

>>> design/tbp_div.sv
module tbp_div #(
    parameter int POS_WIDTH     = 40,
    parameter int ACC_FRAC_BITS = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [tbp_pkg::GM_WIDTH+POS_WIDTH+ACC_FRAC_BITS:0] i_num,
    input  logic [3*(POS_WIDTH+1)-1:0]                         i_den,
    output logic [tbp_pkg::GM_WIDTH+POS_WIDTH+ACC_FRAC_BITS:0] o_quo,
    output logic          o_done
);
    import tbp_pkg::*;

    localparam int M  = POS_WIDTH + 1;
    localparam int NW = GM_WIDTH + M + ACC_FRAC_BITS;
    localparam int DW = 3 * M;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_fin;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DW:0]   rem_sh;
    logic          ge;
    logic          round_up;

    // restoring step, one quotient bit per cycle
    assign rem_sh   = {r_rem, r_num[NW-1]};
    assign ge       = (rem_sh >= {1'b0, r_den});
    assign round_up = ({r_rem, 1'b0} >= {1'b0, r_den});

    assign o_quo  = r_quo;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath, final cycle rounds half up
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= ge ? DW'(rem_sh - {1'b0, r_den}) : DW'(rem_sh);
            r_quo <= {r_quo[NW-2:0], ge};
        end else if (r_fin && round_up) begin
            r_quo <= r_quo + 1'b1;
        end
    end

endmodule

>>> design/tbp_back.sv
module tbp_back #(
    parameter int POS_WIDTH     = 40,
    parameter int ACC_FRAC_BITS = 48
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [6*(POS_WIDTH+1)+6:0]       i_data,
    input  logic                             i_empty,
    output logic                             o_pop,
    input  logic [tbp_pkg::GM_WIDTH-1:0]     i_gm,
    output logic                             o_valid,
    output logic signed [tbp_pkg::ACC_WIDTH-1:0] o_accel [3],
    output logic                             o_saturated,
    output logic                             o_singular
);
    import tbp_pkg::*;

    localparam int M  = POS_WIDTH + 1;
    localparam int QW = 2 * M;
    localparam int DW = 3 * M;
    localparam int AW = DW;
    localparam int PN = GM_WIDTH + M;
    localparam int NW = PN + ACC_FRAC_BITS;
    localparam int TW = NW + 1;
    localparam int XW = NW + 2;
    localparam int CW = $clog2(M);
    localparam int IW = 6 * M + 7;

    t_state                r_state, n_state;
    logic [IW-1:0]         r_item, n_item;
    logic                  r_pass, n_pass;
    logic [1:0]            r_comp, n_comp;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [AW-1:0]         r_ma, n_ma;
    logic [M-1:0]          r_mb, n_mb;
    logic [AW-1:0]         r_acc, n_acc;
    logic [DW-1:0]         r_den, n_den;
    logic signed [TW-1:0]  r_td [3];
    logic signed [TW-1:0]  n_td [3];
    logic signed [ACC_WIDTH-1:0] r_out [3];
    logic signed [ACC_WIDTH-1:0] n_out [3];
    logic                  r_sat, n_sat;
    logic                  r_sing, n_sing;
    logic                  r_valid, n_valid;
    logic                  r_go_sqrt, n_go_sqrt;
    logic                  r_go_div, n_go_div;

    logic [M-1:0]          mag_sel;
    logic                  neg_sel;
    logic [AW-1:0]         mul_step;
    logic [M-1:0]          root;
    logic                  sqrt_done;
    logic [NW-1:0]         quo;
    logic                  div_done;
    logic signed [TW-1:0]  term;
    logic signed [XW-1:0]  diff;
    logic                  fits;

    // operand for the current pass and component
    assign mag_sel = r_pass ? r_item[(32'(r_comp) + 3) * M +: M] : r_item[32'(r_comp) * M +: M];
    assign neg_sel = r_pass ? r_item[6*M + 3 + 32'(r_comp)] : r_item[6*M + 32'(r_comp)];

    // shift-add multiplier step
    assign mul_step = r_mb[0] ? r_acc + r_ma : r_acc;

    // signed term and difference against the direct term
    assign term = neg_sel ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    assign diff = {r_td[r_comp][TW-1], r_td[r_comp]} - {term[TW-1], term};
    assign fits = (&diff[XW-1:ACC_WIDTH-1]) | ~(|diff[XW-1:ACC_WIDTH-1]);

    tbp_sqrt #(
        .POS_WIDTH (POS_WIDTH)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go_sqrt),
        .i_rad   (r_acc[QW-1:0]),
        .o_root  (root),
        .o_done  (sqrt_done)
    );

    tbp_div #(
        .POS_WIDTH     (POS_WIDTH),
        .ACC_FRAC_BITS (ACC_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go_div),
        .i_num   ({r_acc[PN-1:0], {ACC_FRAC_BITS{1'b0}}}),
        .i_den   (r_den),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= 1'b0;
            r_go_sqrt <= 1'b0;
            r_go_div  <= 1'b0;
            r_pass    <= 1'b0;
            r_comp    <= '0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_go_sqrt <= n_go_sqrt;
            r_go_div  <= n_go_div;
            r_pass    <= n_pass;
            r_comp    <= n_comp;
            r_cnt     <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_acc  <= n_acc;
        r_den  <= n_den;
        r_td   <= n_td;
        r_out  <= n_out;
        r_sat  <= n_sat;
        r_sing <= n_sing;
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_pass    = r_pass;
        n_comp    = r_comp;
        n_cnt     = r_cnt;
        n_ma      = r_ma;
        n_mb      = r_mb;
        n_acc     = r_acc;
        n_den     = r_den;
        n_td      = r_td;
        n_out     = r_out;
        n_sat     = r_sat;
        n_sing    = r_sing;
        n_valid   = 1'b0;
        n_go_sqrt = 1'b0;
        n_go_div  = 1'b0;
        o_pop     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_item = i_data;
                    n_sat  = 1'b0;
                    n_pass = 1'b0;
                    n_comp = '0;
                    if (i_data[6*M+6]) begin
                        n_out   = '{default: '0};
                        n_sing  = 1'b1;
                        n_valid = 1'b1;
                    end else begin
                        n_sing  = 1'b0;
                        n_state = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                n_ma  = AW'(mag_sel);
                n_mb  = mag_sel;
                n_cnt = '0;
                if (r_comp == '0) begin
                    n_acc = '0;
                end
                n_state = ST_SQ;
            end
            ST_SQ: begin
                n_acc = mul_step;
                n_ma  = {r_ma[AW-2:0], 1'b0};
                n_mb  = {1'b0, r_mb[M-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(M - 1)) begin
                    if (r_comp == 2'd2) begin
                        n_comp    = '0;
                        n_go_sqrt = 1'b1;
                        n_state   = ST_SQRT;
                    end else begin
                        n_comp  = r_comp + 1'b1;
                        n_state = ST_SETUP;
                    end
                end
            end
            ST_SQRT: begin
                if (sqrt_done) begin
                    n_ma    = AW'(r_acc[QW-1:0]);
                    n_mb    = root;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_state = ST_DEN;
                end
            end
            ST_DEN: begin
                n_acc = mul_step;
                n_ma  = {r_ma[AW-2:0], 1'b0};
                n_mb  = {1'b0, r_mb[M-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(M - 1)) begin
                    n_den   = mul_step;
                    n_state = ST_NSET;
                end
            end
            ST_NSET: begin
                n_ma    = AW'(i_gm);
                n_mb    = mag_sel;
                n_acc   = '0;
                n_cnt   = '0;
                n_state = ST_NUM;
            end
            ST_NUM: begin
                n_acc = mul_step;
                n_ma  = {r_ma[AW-2:0], 1'b0};
                n_mb  = {1'b0, r_mb[M-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(M - 1)) begin
                    n_go_div = 1'b1;
                    n_state  = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (!r_pass) begin
                        n_td[r_comp] = term;
                    end else if (fits) begin
                        n_out[r_comp] = diff[ACC_WIDTH-1:0];
                    end else begin
                        n_sat         = 1'b1;
                        n_out[r_comp] = diff[XW-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                                   : {1'b0, {(ACC_WIDTH-1){1'b1}}};
                    end
                    if (r_comp != 2'd2) begin
                        n_comp  = r_comp + 1'b1;
                        n_state = ST_NSET;
                    end else if (!r_pass) begin
                        n_pass  = 1'b1;
                        n_comp  = '0;
                        n_state = ST_SETUP;
                    end else begin
                        n_valid = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid     = r_valid;
    assign o_accel     = r_out;
    assign o_saturated = r_sat;
    assign o_singular  = r_sing;

    // the two iterative units are never launched together
    a_one_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_go_sqrt && r_go_div))
        else $error("sqrt and divider launched in the same cycle");

    // a result follows either a pop in idle or the last division
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ($past(r_state) == ST_IDLE || $past(r_state) == ST_DIV))
        else $error("result strobe from unexpected state");

    // singular results carry zero acceleration and no saturation
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_sing) |-> (r_out[0] == '0 && r_out[1] == '0 &&
                                 r_out[2] == '0 && !r_sat))
        else $error("singular result with nonzero acceleration");

    // the divider only reports back while a division is awaited
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider done outside division state");

endmodule

>>> design/third_body_perturbation_accel.sv
// Third-body point-mass perturbation acceleration.
// Input transfer: drive the six position ports and raise start; the item is
// taken at a rising edge where start is high and busy is low. busy rises when
// the two-entry input queue is full.
// Result: o_valid is high for exactly one cycle with o_accel_x/y/z (signed,
// 2^-ACC_FRAC_BITS m/s^2), o_saturated and o_singular; the receiver must take
// it in that cycle, results are never held back.
// Config: i_cfg_data is written to the gravitational parameter when
// i_cfg_valid is high (o_cfg_ready is always high); write only while idle.
// Flow: a singular item (zero craft-body distance or body at the origin) is
// popped from the queue when the sequencer is idle and its result leaves through
// the registered o_valid. Other items run through one shared sequencer: per vector three
// serial squares, a serial square root and a serial cube product, then per
// component a serial numerator product and a restoring divide of
// POS_WIDTH + ACC_FRAC_BITS + 49 steps. New items queue while the sequencer
// works.
// Reset: synchronous, active low; the queue empties and the gravitational
// parameter returns to the lunar value.
module third_body_perturbation_accel #(
    parameter int POS_WIDTH     = tbp_pkg::POS_WIDTH_DEF,
    parameter int ACC_FRAC_BITS = tbp_pkg::ACC_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tbp_pkg::GM_WIDTH-1:0]         i_cfg_data,
    input  logic signed [POS_WIDTH-1:0]          i_craft_x,
    input  logic signed [POS_WIDTH-1:0]          i_craft_y,
    input  logic signed [POS_WIDTH-1:0]          i_craft_z,
    input  logic signed [POS_WIDTH-1:0]          i_body_x,
    input  logic signed [POS_WIDTH-1:0]          i_body_y,
    input  logic signed [POS_WIDTH-1:0]          i_body_z,
    output logic                                 o_valid,
    output logic signed [tbp_pkg::ACC_WIDTH-1:0] o_accel_x,
    output logic signed [tbp_pkg::ACC_WIDTH-1:0] o_accel_y,
    output logic signed [tbp_pkg::ACC_WIDTH-1:0] o_accel_z,
    output logic                                 o_saturated,
    output logic                                 o_singular
);
    import tbp_pkg::*;

    localparam int IW = 6 * (POS_WIDTH + 1) + 7;

    logic [GM_WIDTH-1:0]         r_gm;
    logic signed [POS_WIDTH-1:0] craft [3];
    logic signed [POS_WIDTH-1:0] body  [3];
    logic [IW-1:0]               item;
    logic [IW-1:0]               q_data;
    logic                        q_empty;
    logic                        q_full;
    logic                        q_pop;
    logic                        push;
    logic signed [ACC_WIDTH-1:0] accel [3];

    assign craft = '{i_craft_x, i_craft_y, i_craft_z};
    assign body  = '{i_body_x, i_body_y, i_body_z};

    // input transfer
    assign busy = q_full;
    assign push = start & ~q_full;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gm <= GM_RESET;
        end else if (i_cfg_valid) begin
            r_gm <= i_cfg_data;
        end
    end

    tbp_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .i_craft (craft),
        .i_body  (body),
        .o_item  (item)
    );

    tbp_fifo #(
        .WIDTH (IW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (item),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    tbp_back #(
        .POS_WIDTH     (POS_WIDTH),
        .ACC_FRAC_BITS (ACC_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (q_data),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .i_gm        (r_gm),
        .o_valid     (o_valid),
        .o_accel     (accel),
        .o_saturated (o_saturated),
        .o_singular  (o_singular)
    );

    assign o_accel_x = accel[0];
    assign o_accel_y = accel[1];
    assign o_accel_z = accel[2];

endmodule

>>> tb/sv/tbp_accel_checker.sv
module tbp_accel_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic                                 i_cfg_valid,
    input  logic                                 o_cfg_ready,
    input  logic [tbp_pkg::GM_WIDTH-1:0]         i_cfg_data,
    input  logic signed [39:0]                   i_craft_x,
    input  logic signed [39:0]                   i_craft_y,
    input  logic signed [39:0]                   i_craft_z,
    input  logic signed [39:0]                   i_body_x,
    input  logic signed [39:0]                   i_body_y,
    input  logic signed [39:0]                   i_body_z,
    input  logic                                 o_valid,
    input  logic signed [tbp_pkg::ACC_WIDTH-1:0] o_accel_x,
    input  logic signed [tbp_pkg::ACC_WIDTH-1:0] o_accel_y,
    input  logic signed [tbp_pkg::ACC_WIDTH-1:0] o_accel_z,
    input  logic                                 o_saturated,
    input  logic                                 o_singular,
    output int                                   o_errors,
    output int                                   o_pending,
    output int                                   o_singular_seen,
    output int                                   o_saturated_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = tbp_pkg::ACC_FRAC_BITS_DEF;

    typedef logic [191:0] t_wide;
    typedef logic signed [199:0] t_swide;

    localparam t_swide ACC_MAX = 200'sh7FFFFFFFFFFFFFFF;
    localparam t_swide ACC_MIN = -ACC_MAX - 1;

    typedef struct {
        logic signed [63:0] ax;
        logic signed [63:0] ay;
        logic signed [63:0] az;
        logic               sat;
        logic               sing;
    } t_accel;

    logic [tbp_pkg::GM_WIDTH-1:0] gm;
    t_accel                       accel_q[$];

    // floor square root of a sum of squares
    function automatic t_wide floor_sqrt(t_wide n);
        t_wide r;
        t_wide c;
        r = '0;
        for (int b = 55; b >= 0; b--) begin
            c = r | (t_wide'(1) << b);
            if (c * c <= n) r = c;
        end
        return r;
    endfunction

    // one signed component of gm * v / |v|^3, rounded half away from zero
    function automatic t_swide pull_term(logic signed [41:0] v, t_wide den,
                                         logic [47:0] g);
        t_wide m;
        t_wide n;
        t_wide q;
        t_wide r;
        m = t_wide'(v < 0 ? -v : v);
        n = (t_wide'(g) * m) << FRAC;
        q = n / den;
        r = n % den;
        if ((r << 1) >= den) q = q + 1;
        return (v < 0) ? -t_swide'(q) : t_swide'(q);
    endfunction

    function automatic t_wide norm_sq(logic signed [41:0] v[3]);
        t_wide s;
        t_wide m;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            m = t_wide'(v[i] < 0 ? -v[i] : v[i]);
            s = s + m * m;
        end
        return s;
    endfunction

    function automatic t_accel predict_accel(logic signed [39:0] c[3],
                                             logic signed [39:0] b[3],
                                             logic [47:0] g);
        t_accel             res;
        logic signed [41:0] dv[3];
        logic signed [41:0] bv[3];
        t_wide              qd;
        t_wide              qb;
        t_wide              dd;
        t_wide              db;
        t_swide             diff;
        logic signed [63:0] comp[3];
        res = '{default: '0};
        for (int i = 0; i < 3; i++) begin
            bv[i] = 42'(b[i]);
            dv[i] = 42'(b[i]) - 42'(c[i]);
        end
        qd = norm_sq(dv);
        qb = norm_sq(bv);
        if (qd == 0 || qb == 0) begin
            res.sing = 1'b1;
            return res;
        end
        dd = qd * floor_sqrt(qd);
        db = qb * floor_sqrt(qb);
        for (int i = 0; i < 3; i++) begin
            diff = pull_term(dv[i], dd, g) - pull_term(bv[i], db, g);
            if (diff > ACC_MAX) begin
                comp[i] = 64'sh7FFFFFFFFFFFFFFF;
                res.sat = 1'b1;
            end else if (diff < ACC_MIN) begin
                comp[i] = 64'sh8000000000000000;
                res.sat = 1'b1;
            end else begin
                comp[i] = diff[63:0];
            end
        end
        res.ax = comp[0];
        res.ay = comp[1];
        res.az = comp[2];
        return res;
    endfunction

    // watch both channels at every edge
    always @(posedge i_clk) begin
        t_accel exp_r;
        if (!i_rst_n) begin
            gm = tbp_pkg::GM_RESET;
            accel_q.delete();
            o_errors = 0;
            o_singular_seen = 0;
            o_saturated_seen = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) gm = i_cfg_data;
            if (start && !busy)
                accel_q.push_back(predict_accel('{i_craft_x, i_craft_y, i_craft_z},
                                                '{i_body_x, i_body_y, i_body_z}, gm));
            if (o_valid) begin
                if (accel_q.size() == 0) begin
                    $error("result with no transfer pending");
                    o_errors++;
                end else begin
                    exp_r = accel_q.pop_front();
                    if (o_singular) o_singular_seen++;
                    if (o_saturated) o_saturated_seen++;
                    if (o_accel_x !== exp_r.ax) begin
                        $error("accel_x exp %0d got %0d", exp_r.ax, o_accel_x);
                        o_errors++;
                    end
                    if (o_accel_y !== exp_r.ay) begin
                        $error("accel_y exp %0d got %0d", exp_r.ay, o_accel_y);
                        o_errors++;
                    end
                    if (o_accel_z !== exp_r.az) begin
                        $error("accel_z exp %0d got %0d", exp_r.az, o_accel_z);
                        o_errors++;
                    end
                    if (o_saturated !== exp_r.sat) begin
                        $error("saturated exp %0b got %0b", exp_r.sat, o_saturated);
                        o_errors++;
                    end
                    if (o_singular !== exp_r.sing) begin
                        $error("singular exp %0b got %0b", exp_r.sing, o_singular);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = accel_q.size();
    end

endmodule

>>> tb/sv/tb_third_body_perturbation_accel.sv
module tb_third_body_perturbation_accel;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 390;
    localparam int IDLE_LIMIT      = 20000;
    localparam logic [47:0] GM_MAX = 48'hFFFF_FFFF_FFFF;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [47:0]              i_cfg_data = '0;
    logic signed [39:0]       i_craft_x = '0, i_craft_y = '0, i_craft_z = '0;
    logic signed [39:0]       i_body_x = '0, i_body_y = '0, i_body_z = '0;
    logic                     o_valid;
    logic signed [63:0]       o_accel_x, o_accel_y, o_accel_z;
    logic                     o_saturated, o_singular;
    int                       errors, pending, sing_cnt, sat_cnt;
    int                       idle_cycles = 0;
    int                       sent = 0;
    int                       burst_left = 0;

    always #6 i_clk = ~i_clk;

    third_body_perturbation_accel dut (.*);

    tbp_accel_checker chk (
        .*,
        .o_errors(errors),
        .o_pending(pending),
        .o_singular_seen(sing_cnt),
        .o_saturated_seen(sat_cnt)
    );

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic signed [39:0] rnd_pos();
        return 40'({$urandom, $urandom});
    endfunction

    function automatic logic signed [39:0] rnd_small(int span);
        return 40'($signed($urandom_range(2 * span, 0)) - span);
    endfunction

    // one input transfer, with bursts and gaps around it
    task automatic send_pos(logic signed [39:0] cx, cy, cz, bx, by, bz);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            case ($urandom_range(5, 0))
                0:       gap = $urandom_range(3000, 100);
                1, 2:    gap = $urandom_range(8, 1);
                default: gap = 0;
            endcase
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        {i_craft_x, i_craft_y, i_craft_z} <= {cx, cy, cz};
        {i_body_x, i_body_y, i_body_z} <= {bx, by, bz};
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_gm(logic [47:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= val;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_items(int n);
        logic signed [39:0] bx, by, bz;
        int span;
        for (int k = 0; k < n; k++) begin
            bx = rnd_pos();
            by = rnd_pos();
            bz = rnd_pos();
            case ($urandom_range(9, 0))
                0, 1, 2: send_pos(rnd_pos(), rnd_pos(), rnd_pos(), bx, by, bz);
                3, 4: begin
                    // spacecraft near the body
                    span = 1 << $urandom_range(30, 0);
                    send_pos(bx + rnd_small(span), by + rnd_small(span),
                             bz + rnd_small(span), bx, by, bz);
                end
                5, 6: begin
                    // small geometry, drives saturation
                    span = 1 << $urandom_range(12, 0);
                    send_pos(rnd_small(span), rnd_small(span), rnd_small(span),
                             rnd_small(span), rnd_small(span), rnd_small(span));
                end
                7: send_pos(bx, by, bz, bx, by, bz);
                8: send_pos(rnd_pos(), rnd_pos(), rnd_pos(), '0, '0, '0);
                default: begin
                    // earth-moon like distances
                    span = 400000000;
                    send_pos(rnd_small(7000000), rnd_small(7000000), rnd_small(7000000),
                             rnd_small(span), rnd_small(span), rnd_small(span));
                end
            endcase
        end
    endtask

    localparam logic signed [39:0] PMAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] PMIN = 40'sh80_0000_0000;

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners at the reset gravitational parameter
        send_pos(PMAX, PMAX, PMAX, PMIN, PMIN, PMIN);
        send_pos(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX);
        send_pos(PMIN, PMAX, PMIN, PMAX, PMIN, PMAX);
        send_pos('0, '0, '0, 40'sd384400000, '0, '0);
        send_pos(40'sd6778000, '0, '0, 40'sd384400000, '0, '0);
        send_pos(40'sd5, 40'sd5, 40'sd5, 40'sd5, 40'sd5, 40'sd5);
        send_pos(40'sd100, -40'sd3, 40'sd7, '0, '0, '0);
        send_pos('0, '0, '0, '0, '0, '0);
        send_pos('0, '0, '0, 40'sd1, '0, '0);
        send_pos('0, '0, 40'sd1, '0, '0, -40'sd1);
        send_pos(-40'sd1, -40'sd1, -40'sd1, 40'sd1, 40'sd1, 40'sd1);
        send_pos(PMAX, '0, '0, PMAX - 1, '0, '0);
        random_items(ITEMS_PER_PHASE - 12);

        write_gm('0);
        send_pos('0, '0, '0, 40'sd1, '0, '0);
        random_items(ITEMS_PER_PHASE);

        write_gm(GM_MAX);
        send_pos('0, '0, '0, 40'sd1, 40'sd1, '0);
        send_pos(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX);
        random_items(ITEMS_PER_PHASE);

        write_gm(48'({$urandom, $urandom}));
        random_items(ITEMS_PER_PHASE);

        write_gm(tbp_pkg::GM_RESET);
        random_items(ITEMS_PER_PHASE);

        drain();
        repeat (20) @(posedge i_clk);
        $display("sent %0d positions over five gravity settings (zero, max, random, lunar)",
                 sent);
        $display("singular results %0d, saturated results %0d", sing_cnt, sat_cnt);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/tbp_pkg.sv
design/tbp_front.sv
design/tbp_fifo.sv
design/tbp_sqrt.sv
design/tbp_div.sv
design/tbp_back.sv
design/third_body_perturbation_accel.sv
tb/sv/tbp_accel_checker.sv
tb/sv/tb_third_body_perturbation_accel.sv
